/* hw/rtl/kle_pkg.sv */
// Shared types and constants for the keymap line tokenizer.
package kle_pkg;

    localparam int MAX_RES = 5;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_XU    = 8'h58;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam int FB_QUOTE   = 0;
    localparam int FB_COMMENT = 1;
    localparam int FB_AFTER_EQ = 2;
    localparam int FB_ESC     = 3;
    localparam int FB_HEX     = 4;
    localparam int FB_DEC     = 5;
    localparam int FB_OCT     = 6;
    localparam int FB_ZERO    = 7;

    localparam logic [20:0] ACC_MAX = 21'h1FFFFF;

    // results caused by one input item
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] data;
        logic [2:0]              cnt;
        logic                    conv;
        logic                    line_end;
    } t_bundle;

endpackage

/* hw/rtl/kle_decode.sv */
// Tokenizer state registers and the per-item decode into a result bundle.
module kle_decode
    import kle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_byte,
    input  logic       i_adv,
    output t_bundle    o_bnd
);

    logic [7:0]  r_flags;
    logic [20:0] r_acc;
    logic [7:0]  n_flags;
    logic [20:0] n_acc;

    logic [4:0]       v;
    logic [24:0]      t16, t8, t10;
    logic [3:0][7:0]  enc;
    logic [2:0]       enc_cnt;
    logic [3:0][7:0]  pre;
    logic [2:0]       pre_cnt;
    logic             emit_p;
    logic             le;
    logic             conv;
    logic             is_x;

    function automatic logic [4:0] digit_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
        if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
        return 5'd16;
    endfunction

    function automatic logic [20:0] sat(input logic [24:0] t);
        return (t > 25'(ACC_MAX)) ? ACC_MAX : t[20:0];
    endfunction

    assign v    = digit_val(i_byte);
    assign is_x = (i_byte == CH_X) || (i_byte == CH_XU);
    assign t16  = {r_acc, 4'b0} + 25'(v[3:0]);
    assign t8   = 25'({r_acc, 3'b0}) + 25'(v[3:0]);
    assign t10  = 25'({r_acc, 3'b0}) + 25'({r_acc, 1'b0}) + 25'(v[3:0]);

    // UTF-8 form of the pending code point
    always_comb begin
        enc = '0;
        if (r_acc < 21'h80) begin
            enc_cnt = 3'd1;
            enc[0]  = r_acc[7:0];
        end else if (r_acc < 21'h800) begin
            enc_cnt = 3'd2;
            enc[0]  = {3'b110, r_acc[10:6]};
            enc[1]  = {2'b10, r_acc[5:0]};
        end else if (r_acc < 21'h10000) begin
            enc_cnt = 3'd3;
            enc[0]  = {4'b1110, r_acc[15:12]};
            enc[1]  = {2'b10, r_acc[11:6]};
            enc[2]  = {2'b10, r_acc[5:0]};
        end else begin
            enc_cnt = 3'd4;
            enc[0]  = {5'b11110, r_acc[20:18]};
            enc[1]  = {2'b10, r_acc[17:12]};
            enc[2]  = {2'b10, r_acc[11:6]};
            enc[3]  = {2'b10, r_acc[5:0]};
        end
    end

    always_comb begin
        n_flags = r_flags;
        n_acc   = r_acc;
        pre     = '0;
        pre_cnt = 3'd0;
        emit_p  = 1'b0;
        le      = 1'b0;
        conv    = 1'b0;
        if (i_byte == CH_NL) begin
            n_flags = '0;
            n_acc   = '0;
            le      = 1'b1;
        end else if (r_flags[FB_QUOTE] || r_flags[FB_AFTER_EQ]) begin
            conv = !r_flags[FB_QUOTE];
            // close out a pending number, zero or escape
            if (r_flags[FB_ZERO]) begin
                n_flags[FB_ZERO] = 1'b0;
                if (v < 5'd8) begin
                    n_acc            = 21'(v);
                    n_flags[FB_OCT]  = 1'b1;
                end else if (is_x) begin
                    n_acc            = '0;
                    n_flags[FB_HEX]  = 1'b1;
                end else begin
                    pre_cnt = 3'd1;
                    pre[0]  = CH_ZERO;
                end
            end else if (r_flags[FB_HEX]) begin
                if (v < 5'd16) begin
                    n_acc = sat(t16);
                end else begin
                    n_flags[FB_HEX] = 1'b0;
                    pre     = enc;
                    pre_cnt = enc_cnt;
                end
            end else if (r_flags[FB_OCT]) begin
                if (v < 5'd8) begin
                    n_acc = sat(t8);
                end else begin
                    n_flags[FB_OCT] = 1'b0;
                    pre     = enc;
                    pre_cnt = enc_cnt;
                end
            end else if (r_flags[FB_DEC]) begin
                if (v < 5'd10) begin
                    n_acc = sat(t10);
                end else begin
                    n_flags[FB_DEC] = 1'b0;
                    pre     = enc;
                    pre_cnt = enc_cnt;
                end
            end else if (r_flags[FB_ESC]) begin
                n_acc           = '0;
                n_flags[FB_ESC] = 1'b0;
                if (i_byte == CH_ZERO) begin
                    n_flags[FB_OCT] = 1'b1;
                end else if (is_x) begin
                    n_flags[FB_HEX] = 1'b1;
                end else if (v < 5'd16) begin
                    n_flags[FB_DEC] = 1'b1;
                    n_acc           = 21'(v);
                end else begin
                    pre_cnt = 3'd1;
                    pre[0]  = i_byte;
                end
            end
            // plain handling of the byte
            if (!(n_flags[FB_HEX] || n_flags[FB_DEC] || n_flags[FB_OCT])
                && !r_flags[FB_ESC]) begin
                if (i_byte == CH_QUOTE) begin
                    n_flags = '0;
                end else if (i_byte == CH_EQ) begin
                    n_flags[FB_QUOTE]    = 1'b0;
                    n_flags[FB_AFTER_EQ] = 1'b1;
                end else if (i_byte == CH_ZERO) begin
                    n_flags[FB_ZERO] = 1'b1;
                end else if (v < 5'd10) begin
                    n_flags[FB_DEC] = 1'b1;
                    n_acc           = 21'(v);
                end else if (i_byte == CH_BSL) begin
                    n_flags[FB_ESC] = 1'b1;
                end else if (i_byte != CH_SPACE) begin
                    emit_p = 1'b1;
                end
            end
        end else if (r_flags[FB_COMMENT]) begin
            n_flags = r_flags;
        end else if (i_byte == CH_QUOTE) begin
            n_flags[FB_QUOTE] = 1'b1;
        end else if (i_byte == CH_SLASH) begin
            n_flags[FB_COMMENT] = 1'b1;
        end
    end

    always_comb begin
        o_bnd.line_end = le;
        o_bnd.conv     = conv;
        if (le) begin
            o_bnd.cnt  = 3'd1;
            o_bnd.data = '0;
        end else begin
            o_bnd.cnt     = pre_cnt + {2'b0, emit_p};
            o_bnd.data[0] = (pre_cnt > 3'd0) ? pre[0] : i_byte;
            o_bnd.data[1] = (pre_cnt > 3'd1) ? pre[1] : i_byte;
            o_bnd.data[2] = (pre_cnt > 3'd2) ? pre[2] : i_byte;
            o_bnd.data[3] = (pre_cnt > 3'd3) ? pre[3] : i_byte;
            o_bnd.data[4] = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_acc   <= '0;
        end else if (i_adv) begin
            r_flags <= n_flags;
            r_acc   <= n_acc;
        end
    end

    a_num_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_flags[FB_HEX], r_flags[FB_DEC], r_flags[FB_OCT]}))
        else $error("more than one number mode open");

    a_nl_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_byte == CH_NL |=> r_flags == '0 && r_acc == '0)
        else $error("newline did not clear state");

    a_mode_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_flags[FB_QUOTE] && r_flags[FB_AFTER_EQ]) &&
        !(r_flags[FB_COMMENT] && (r_flags[FB_QUOTE] || r_flags[FB_AFTER_EQ])))
        else $error("string and comment modes overlap");

endmodule

/* hw/rtl/kle_serial.sv */
// Result bundle register that hands out its results one per cycle while i_stall is low.
module kle_serial
    import kle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_bundle    i_bnd,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_to_conversion,
    output logic       o_line_end,
    output logic       o_last,
    output logic       o_free
);

    logic       r_vld;
    logic [2:0] r_idx;
    t_bundle    r_bnd;
    logic       last;

    assign last            = (r_idx == r_bnd.cnt - 3'd1);
    assign o_valid         = r_vld;
    assign o_out_byte      = r_bnd.data[r_idx];
    assign o_to_conversion = r_bnd.conv;
    assign o_line_end      = r_bnd.line_end;
    assign o_last          = last;
    assign o_free          = !r_vld || (!i_stall && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_idx <= '0;
        end else if (r_vld && !i_stall) begin
            if (last) begin
                r_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bnd <= i_bnd;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free && i_bnd.cnt != 3'd0)
        else $error("bundle loaded while busy or empty");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> r_bnd.cnt != 3'd0 && r_idx < r_bnd.cnt)
        else $error("result index out of range");

    a_le_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && o_line_end |-> o_last && !o_to_conversion && o_out_byte == 8'h00)
        else $error("line-end result not alone");

endmodule

/* hw/rtl/keymap_line_escape_tokenizer.sv */
// Top level: input register, decode stage and result serializer.
// An accepted item goes through the input register and decode stage into the serializer register.
// Throughput: one item per cycle while each item gives at most one result and i_stall is
// low; an item with more results (up to 5, from UTF-8 flushes) holds the result port for all of them.
// Reset (synchronous, active low) clears mode flags, code accumulator and all valids.
module keymap_line_escape_tokenizer
    import kle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_to_conversion,
    output logic       o_line_end,
    output logic       o_last
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    t_bundle    bnd;
    logic       free;
    logic       in_move;

    assign in_move = r_in_vld && (bnd.cnt == 3'd0 || free);
    assign o_stall = r_in_vld && !in_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    kle_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (r_in_byte),
        .i_adv   (in_move),
        .o_bnd   (bnd)
    );

    kle_serial u_serial (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (in_move && bnd.cnt != 3'd0),
        .i_bnd           (bnd),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_to_conversion (o_to_conversion),
        .o_line_end      (o_line_end),
        .o_last          (o_last),
        .o_free          (free)
    );

endmodule
